[hw/rtl/kfi_pkg.sv]
`timescale 1ns / 1ps

package kfi_pkg;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_EVAL   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] time_req;
        logic [7:0]  shape;
    } kfi_req_t;

    typedef struct packed {
        logic [14:0]        mouth_open;
        logic signed [15:0] mouth_form;
        logic [1:0]         status;
    } kfi_res_t;

    // broadcast from control to every cell
    typedef struct packed {
        logic        ins;
        logic [31:0] t;
        logic [3:0]  code;
    } kfi_op_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic        hit;
        logic [31:0] lo_t;
        logic [3:0]  lo_s;
        logic [31:0] hi_t;
        logic [3:0]  hi_s;
        logic [31:0] last_t;
        logic [3:0]  last_s;
    } kfi_bus_t;

    function automatic logic [3:0] shape_code(input logic [7:0] letter);
        logic [7:0] d;
        begin
            d = letter - 8'h40;
            if (letter >= 8'h41 && letter <= 8'h48)
                shape_code = d[3:0];
            else
                shape_code = 4'd0;
        end
    endfunction

    function automatic logic [14:0] open_of(input logic [3:0] c);
        case (c)
            4'd1:    open_of = 15'd1638;
            4'd2:    open_of = 15'd16384;
            4'd3:    open_of = 15'd13107;
            4'd4:    open_of = 15'd4915;
            4'd5:    open_of = 15'd9830;
            4'd6:    open_of = 15'd3277;
            4'd7:    open_of = 15'd6554;
            4'd8:    open_of = 15'd4915;
            default: open_of = 15'd0;
        endcase
    endfunction

    function automatic logic signed [15:0] form_of(input logic [3:0] c);
        case (c)
            4'd1:    form_of = -16'sd16384;
            4'd3:    form_of = 16'sd8192;
            4'd5:    form_of = 16'sd8192;
            4'd6:    form_of = -16'sd8192;
            4'd8:    form_of = 16'sd4915;
            default: form_of = 16'sd0;
        endcase
    endfunction

endpackage

[hw/rtl/keyframe_linear_interpolator.sv]
`timescale 1ns / 1ps

// Keyframe table of up to MAX_KEYFRAMES entries kept in a row of cells, one
// keyframe per cell, sorted by time. Clear and append go from the idle state
// to the finish state and then to the result register; an append shifts
// every later cell up by one on the edge that accepts it. An evaluate sends a
// search token down the whole row, one cell per cycle, then runs a restoring
// divider for the 16-bit blend fraction and a multiply step. Queries at or
// beyond an end, or exactly on a keyframe time, skip the divider. One request
// is in flight at a time; the next is taken while the previous result still
// waits.
module keyframe_linear_interpolator #(
    parameter int MAX_KEYFRAMES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  kfi_pkg::kfi_req_t req_data,
    output logic              res_valid,
    input  logic              res_stall,
    output kfi_pkg::kfi_res_t res_data
);
    import kfi_pkg::*;

    localparam int CW = $clog2(MAX_KEYFRAMES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]    state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] cnt_reg;
    logic [3:0]    dcnt_reg;
    logic [31:0]   t_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   span_reg;
    logic [15:0]   q_reg;
    logic [3:0]    ca_reg;
    logic [3:0]    cb_reg;
    kfi_res_t      result_reg;
    logic          res_valid_reg;
    kfi_res_t      res_data_reg;

    logic          acc;
    kfi_op_t       op;
    kfi_res_t      idle_res;

    // cell row wiring
    logic [31:0] cell_time [MAX_KEYFRAMES];
    logic [3:0]  cell_code [MAX_KEYFRAMES];
    kfi_bus_t    cell_bus  [MAX_KEYFRAMES];

    assign req_stall = (state_reg != ST_IDLE);
    assign acc       = req_valid && !req_stall;

    always_comb
    begin
        op.ins  = acc && (req_data.kind == KIND_APPEND)
                  && (count_reg != CW'(MAX_KEYFRAMES));
        op.t    = acc ? req_data.time_req : t_reg;
        op.code = shape_code(req_data.shape);
    end

    // result for requests that finish without a search
    always_comb
    begin
        idle_res = '0;
        if (req_data.kind == KIND_APPEND && count_reg == CW'(MAX_KEYFRAMES))
            idle_res.status = STATUS_FULL;
        else if (req_data.kind == KIND_EVAL && count_reg == '0)
            idle_res.status = STATUS_EMPTY;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEYFRAMES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                kfi_cell #(.IDX(gi), .CW(CW)) u_cell (
                    .clk       (clk),
                    .count     (count_reg),
                    .op        (op),
                    .left_time (32'd0),
                    .left_code (4'd0),
                    .time_q    (cell_time[gi]),
                    .code_q    (cell_code[gi]),
                    .bus_in    ('0),
                    .bus_out   (cell_bus[gi])
                );
            end
            else
            begin : g_body
                kfi_cell #(.IDX(gi), .CW(CW)) u_cell (
                    .clk       (clk),
                    .count     (count_reg),
                    .op        (op),
                    .left_time (cell_time[gi-1]),
                    .left_code (cell_code[gi-1]),
                    .time_q    (cell_time[gi]),
                    .code_q    (cell_code[gi]),
                    .bus_in    (cell_bus[gi-1]),
                    .bus_out   (cell_bus[gi])
                );
            end
        end
    endgenerate

    kfi_bus_t tail;
    assign tail = cell_bus[MAX_KEYFRAMES-1];

    // divider step: remainder stays below span
    logic [32:0] rem2;
    logic        take;
    logic [32:0] rem_sub;
    assign rem2    = {rem_reg, 1'b0};
    assign take    = rem2 >= {1'b0, span_reg};
    assign rem_sub = rem2 - {1'b0, span_reg};

    // blend: a + floor((b - a) * frac / 65536)
    logic signed [16:0] oa;
    logic signed [16:0] od;
    logic signed [16:0] fa;
    logic signed [16:0] fd;
    logic signed [16:0] fr;
    logic signed [33:0] op_prod;
    logic signed [33:0] fp_prod;
    logic signed [33:0] op_sh;
    logic signed [33:0] fp_sh;
    logic signed [16:0] open_sum;
    logic signed [16:0] form_sum;

    always_comb
    begin
        oa       = $signed({2'b00, open_of(ca_reg)});
        od       = $signed({2'b00, open_of(cb_reg)}) - oa;
        fa       = 17'(form_of(ca_reg));
        fd       = 17'(form_of(cb_reg)) - fa;
        fr       = $signed({1'b0, q_reg});
        op_prod  = od * fr;
        fp_prod  = fd * fr;
        op_sh    = op_prod >>> 16;
        fp_sh    = fp_prod >>> 16;
        open_sum = oa + op_sh[16:0];
        form_sum = fa + fp_sh[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // the finish state reloads the output whenever it would drain
            if (res_valid_reg && !res_stall && state_reg != ST_FIN)
                res_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        t_reg      <= req_data.time_req;
                        result_reg <= idle_res;
                        cnt_reg    <= '0;
                        state_reg  <= ST_FIN;
                        case (req_data.kind)
                            KIND_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            KIND_APPEND:
                            begin
                                if (count_reg != CW'(MAX_KEYFRAMES))
                                    count_reg <= count_reg + 1'b1;
                            end
                            KIND_EVAL:
                            begin
                                if (count_reg != '0)
                                    state_reg <= ST_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // token needs one edge per cell to reach the tail
                    if (cnt_reg == CW'(MAX_KEYFRAMES))
                    begin
                        if (t_reg <= cell_time[0])
                        begin
                            result_reg.mouth_open <= open_of(cell_code[0]);
                            result_reg.mouth_form <= form_of(cell_code[0]);
                            state_reg <= ST_FIN;
                        end
                        else if (t_reg >= tail.last_t)
                        begin
                            result_reg.mouth_open <= open_of(tail.last_s);
                            result_reg.mouth_form <= form_of(tail.last_s);
                            state_reg <= ST_FIN;
                        end
                        else if (t_reg == tail.hi_t)
                        begin
                            // full fraction lands exactly on the upper keyframe
                            result_reg.mouth_open <= open_of(tail.hi_s);
                            result_reg.mouth_form <= form_of(tail.hi_s);
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            rem_reg   <= t_reg - tail.lo_t;
                            span_reg  <= tail.hi_t - tail.lo_t;
                            ca_reg    <= tail.lo_s;
                            cb_reg    <= tail.hi_s;
                            dcnt_reg  <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= take ? rem_sub[31:0] : rem2[31:0];
                    q_reg    <= {q_reg[14:0], take};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 4'd15)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    result_reg.mouth_open <= open_sum[14:0];
                    result_reg.mouth_form <= form_sum[15:0];
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_data_reg  <= result_reg;
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEYFRAMES))
        else $error("keyframe count above table size");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below span");

    a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result issued outside finish state");

    a_scan_table_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (count_reg == $past(count_reg)))
        else $error("table changed during search");

endmodule

[hw/rtl/kfi_cell.sv]
`timescale 1ns / 1ps

module kfi_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic             clk,
    input  logic [CW-1:0]    count,
    input  kfi_pkg::kfi_op_t op,
    input  logic [31:0]      left_time,
    input  logic [3:0]       left_code,
    output logic [31:0]      time_q,
    output logic [3:0]       code_q,
    input  kfi_pkg::kfi_bus_t bus_in,
    output kfi_pkg::kfi_bus_t bus_out
);
    import kfi_pkg::*;

    localparam bit FIRST = (IDX == 0);

    logic [31:0] time_reg;
    logic [3:0]  code_reg;
    logic        occupied;
    logic        at_end;
    logic        left_le;
    logic        flag;
    kfi_bus_t    bus_reg;
    kfi_bus_t    bus_next;

    assign occupied = count > CW'(IDX);
    assign at_end   = count == CW'(IDX);
    assign left_le  = FIRST || (left_time <= op.t);

    // stable insert: larger times move up one cell
    always_ff @(posedge clk)
    begin
        if (op.ins && ((occupied && time_reg > op.t) || at_end))
        begin
            if (left_le)
            begin
                time_reg <= op.t;
                code_reg <= op.code;
            end
            else
            begin
                time_reg <= left_time;
                code_reg <= left_code;
            end
        end
    end

    // first cell whose time reaches the query
    assign flag = occupied && (time_reg >= op.t) && (FIRST || left_time < op.t);

    always_comb
    begin
        bus_next = bus_in;
        if (occupied)
        begin
            bus_next.last_t = time_reg;
            bus_next.last_s = code_reg;
        end
        if (flag && !bus_in.hit)
        begin
            bus_next.hit  = 1'b1;
            bus_next.lo_t = left_time;
            bus_next.lo_s = left_code;
            bus_next.hi_t = time_reg;
            bus_next.hi_s = code_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    assign time_q  = time_reg;
    assign code_q  = code_reg;
    assign bus_out = bus_reg;

endmodule

[sim/keyframe_linear_interpolator_test.sv]
`timescale 1ns / 1ps

module keyframe_linear_interpolator_test;
    import kfi_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1500;
    localparam int HOLD_LEN = 400;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Expected mouth state per shape code (Q2.14): closed, then A..H.
    localparam int OPEN_Q14 [9] = '{0, 1638, 16384, 13107, 4915, 9830, 3277, 6554, 4915};
    localparam int FORM_Q14 [9] = '{0, -16384, 0, 8192, 0, 8192, -8192, 0, 4915};

    // Keeps a shadow keyframe table and the queue of pending mouth results.
    class mouth_scoreboard;
        logic [31:0] key_t [TABLE_DEPTH];
        int          key_code [TABLE_DEPTH];
        int          key_n;
        kfi_res_t    pending [$];
        int          mismatches;
        int          n_checked;

        function int code_of(logic [7:0] letter);
            if (letter >= "A" && letter <= "H")
                return int'(letter) - int'("A") + 1;
            return 0;
        endfunction

        // Floored a + (b - a) * frac / 2^16.
        function int mix(int a, int b, longint frac);
            longint p;
            longint q;
            p = longint'(b - a) * frac;
            q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
            return a + int'(q);
        endfunction

        function void note_request(kfi_req_t r);
            kfi_res_t e;
            int pos;
            int lo;
            int hi;
            int mid;
            longint span;
            longint frac;
            e = '0;
            if (r.kind == KIND_CLEAR)
                key_n = 0;
            else if (r.kind == KIND_APPEND) begin
                if (key_n >= TABLE_DEPTH)
                    e.status = STATUS_FULL;
                else begin
                    // stable insert: equal times stay ahead of the new one
                    pos = key_n;
                    while (pos > 0 && key_t[pos-1] > r.time_req) begin
                        key_t[pos] = key_t[pos-1];
                        key_code[pos] = key_code[pos-1];
                        pos--;
                    end
                    key_t[pos] = r.time_req;
                    key_code[pos] = code_of(r.shape);
                    key_n++;
                end
            end else if (r.kind == KIND_EVAL) begin
                if (key_n == 0)
                    e.status = STATUS_EMPTY;
                else if (r.time_req <= key_t[0]) begin
                    e.mouth_open = 15'(OPEN_Q14[key_code[0]]);
                    e.mouth_form = 16'(FORM_Q14[key_code[0]]);
                end else if (r.time_req >= key_t[key_n-1]) begin
                    e.mouth_open = 15'(OPEN_Q14[key_code[key_n-1]]);
                    e.mouth_form = 16'(FORM_Q14[key_code[key_n-1]]);
                end else begin
                    lo = 0;
                    hi = key_n - 1;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (key_t[mid] < r.time_req)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    if (lo == 0)
                        lo = 1;
                    span = longint'(key_t[lo]) - longint'(key_t[lo-1]);
                    frac = 0;
                    if (span != 0)
                        frac = ((longint'(r.time_req) - longint'(key_t[lo-1])) <<< 16)
                            / span;
                    if (frac > 65536)
                        frac = 65536;
                    e.mouth_open = 15'(mix(OPEN_Q14[key_code[lo-1]],
                        OPEN_Q14[key_code[lo]], frac));
                    e.mouth_form = 16'(mix(FORM_Q14[key_code[lo-1]],
                        FORM_Q14[key_code[lo]], frac));
                end
            end
            pending = {pending, e};
        endfunction

        function void check_result(kfi_res_t got);
            kfi_res_t e;
            n_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.mouth_open !== e.mouth_open || got.mouth_form !== e.mouth_form
                    || got.status !== e.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected open %0d form %0d status %0d, got %0d %0d %0d",
                        e.mouth_open, e.mouth_form, e.status,
                        got.mouth_open, got.mouth_form, got.status);
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    kfi_req_t req_data;
    logic     res_valid;
    logic     res_stall;
    kfi_res_t res_data;

    mouth_scoreboard board;
    int  idle_pct_in;          // sender idle percentage
    int  idle_pct_out;         // receiver idle percentage
    int  hold_reqs;            // long receiver stalls asked for by the sender
    int  hold_seen;            // long receiver stalls started
    int  hold_cycles;          // cycles left in the current long stall
    int  quiet_cycles;
    bit  timed_out;
    int  n_sent;
    int  n_evals;

    keyframe_linear_interpolator #(.MAX_KEYFRAMES(TABLE_DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            hold_seen <= 0;
            hold_cycles <= 0;
        end else begin
            if (res_valid && !res_stall)
                board.check_result(res_data);
            if (hold_reqs != hold_seen) begin
                hold_seen <= hold_reqs;
                hold_cycles <= HOLD_LEN;
                res_stall <= 1'b1;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                res_stall <= 1'b1;
            end else
                res_stall <= ($urandom_range(99) < idle_pct_out);
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one request; holds it until accepted, then idles at random.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] t,
                                input logic [7:0] shape);
        kfi_req_t r;
        r.kind = kind;
        r.time_req = t;
        r.shape = shape;
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
        n_sent++;
        if (kind == KIND_EVAL)
            n_evals++;
        if ($urandom_range(99) < idle_pct_in) begin
            req_valid <= 1'b0;
            req_data <= 42'({$urandom, $urandom});
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 30)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_shape();
        case ($urandom_range(9))
            0:       return 8'($urandom);
            1:       return "X";
            default: return 8'("A" + $urandom_range(7));
        endcase
    endfunction

    // Near-keyframe times, so equal times, ends and brackets all get hit.
    function automatic logic [31:0] pick_time(logic [31:0] base);
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return base;
            2:       return base + $urandom_range(3);
            3:       return base - $urandom_range(3);
            default: return base + $urandom_range(16'hffff) - 32'h8000;
        endcase
    endfunction

    initial
    begin
        logic [31:0] base;
        int          n_keys;
        board = new();
        idle_pct_in = 0;
        idle_pct_out = 0;
        hold_reqs = 0;
        n_sent = 0;
        n_evals = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, ends, stable ties, full table, ignored kind.
        send_request(KIND_EVAL, 32'h0, "A");
        send_request(KIND_APPEND, 32'h0001_0000, "B");
        send_request(KIND_APPEND, 32'h0000_0000, "A");
        send_request(KIND_APPEND, 32'hffff_ffff, "H");
        send_request(KIND_APPEND, 32'h0001_0000, "C");   // ties after the B
        send_request(KIND_APPEND, 32'h0002_0000, 8'hff);
        send_request(KIND_EVAL, 32'h0, 8'h0);
        send_request(KIND_EVAL, 32'h0000_8000, 8'h0);
        send_request(KIND_EVAL, 32'h0001_0000, 8'h0);
        send_request(KIND_EVAL, 32'h0001_8000, 8'h0);
        send_request(KIND_EVAL, 32'h8000_0000, 8'h0);
        send_request(KIND_EVAL, 32'hffff_ffff, 8'h0);
        send_request(KIND_SPARE, 32'h1234_5678, "D");
        send_request(KIND_EVAL, 32'hffff_fffe, 8'h0);
        for (int i = 0; i < TABLE_DEPTH - 5; i++)
            send_request(KIND_APPEND, $urandom, pick_shape());
        send_request(KIND_APPEND, 32'h5, "E");            // dropped, table full
        send_request(KIND_EVAL, 32'h7fff_0000, 8'h0);
        send_request(KIND_CLEAR, $urandom, 8'($urandom));
        send_request(KIND_EVAL, 32'h1, 8'h0);
        drain();

        // Long receiver hold-off while requests keep coming.
        hold_reqs = hold_reqs + 1;
        for (int i = 0; i < 12; i++)
            send_request(KIND_APPEND, $urandom, pick_shape());
        drain();

        // Random: sets of keyframes followed by queries, some noise.
        while (n_sent < N_RANDOM) begin
            idle_pct_in = ($urandom_range(4) == 0) ? 0 : 25;
            idle_pct_out = ($urandom_range(4) == 0) ? 0 : 25;
            send_request(KIND_CLEAR, $urandom, 8'($urandom));
            base = $urandom;
            n_keys = ($urandom_range(7) == 0) ? $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 2)
                                              : $urandom_range(1, 10);
            for (int i = 0; i < n_keys; i++)
                send_request(KIND_APPEND, pick_time(base), pick_shape());
            for (int i = 0; i < $urandom_range(2, 12); i++) begin
                if ($urandom_range(15) == 0)
                    send_request(2'($urandom), $urandom, 8'($urandom));
                else
                    send_request(KIND_EVAL, pick_time(base), 8'($urandom));
            end
        end
        drain();

        $display("%0d requests sent, %0d evaluations, %0d results checked",
            n_sent, n_evals, board.n_checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/kfi_pkg.sv
hw/rtl/kfi_cell.sv
hw/rtl/keyframe_linear_interpolator.sv
sim/keyframe_linear_interpolator_test.sv
